@@ rtl/dht_pkg.sv @@
// Shared types and constants for the double-hashing key table.
// Used by dht_hash, dht_mem and double_hash_table; depends on nothing.
`default_nettype none

package dht_pkg;

  localparam int KEY_W  = 48;
  localparam int SLOT_W = 8;
  localparam int STAT_W = 4;
  localparam int SUM_W  = 18;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_READ   = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  localparam logic [1:0] MARK_EMPTY    = 2'd0;
  localparam logic [1:0] MARK_OCCUPIED = 2'd1;
  localparam logic [1:0] MARK_DELETED  = 2'd2;

  localparam logic [STAT_W-1:0] ST_HOME      = 4'd0;
  localparam logic [STAT_W-1:0] ST_PROBED    = 4'd1;
  localparam logic [STAT_W-1:0] ST_EVICTED   = 4'd2;
  localparam logic [STAT_W-1:0] ST_FOUND     = 4'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 4'd4;
  localparam logic [STAT_W-1:0] ST_OCCUPIED  = 4'd5;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 4'd6;
  localparam logic [STAT_W-1:0] ST_DELETED   = 4'd7;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 4'd8;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 4'd9;

  typedef struct packed {
    logic              rd_en;
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [1:0]        wmark;
    logic [KEY_W-1:0]  wkey;
  } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/dht_hash.sv @@
// Iterative hash unit: one 8x8 multiplier accumulates the sum of the three byte-pair products in turn,
// then reciprocal multiplications and a remainder step give the home slot and the probe step.
// Depends on dht_pkg.
`default_nettype none

module dht_hash import dht_pkg::*; #(
  parameter int TABLE_SIZE = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [KEY_W-1:0]      key,
  output logic                       done,
  output logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] home,
  output logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] step
);

  localparam int IW  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam logic [IW:0] NV = (IW + 1)'(TABLE_SIZE);
  localparam int RW  = SUM_W + 2;
  localparam int PW  = SUM_W + RW;
  localparam int SHN = SUM_W + IW;
  localparam int SH3 = SUM_W + 2;
  localparam logic [RW-1:0] RECIP_N = RW'(((1 << SHN) + TABLE_SIZE - 1) / TABLE_SIZE);
  localparam logic [RW-1:0] RECIP_3 = RW'(((1 << SH3) + 2) / 3);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MUL  = 4'b0010,
    H_DIV  = 4'b0100,
    H_REM  = 4'b1000
  } hstate_t;

  hstate_t          hstate;
  logic [KEY_W-1:0] key_q;
  logic [SUM_W-1:0] acc;
  logic [1:0]       cnt;
  logic [SUM_W-1:0] qn;
  logic [SUM_W-1:0] q3;
  logic [IW-1:0]    rn;
  logic [1:0]       r3;

  logic [7:0]       op_a;
  logic [7:0]       op_b;
  logic [15:0]      prod;
  logic [PW-1:0]    prod_n;
  logic [PW-1:0]    prod_3;
  logic [SUM_W-1:0] rem_n;
  logic [SUM_W-1:0] rem_3;
  logic [IW:0]      step_raw;
  logic [IW:0]      step_red;

  always_comb begin
    case (cnt)
      2'd0: begin
        op_a = key_q[47:40];
        op_b = key_q[39:32];
      end
      2'd1: begin
        op_a = key_q[31:24];
        op_b = key_q[23:16];
      end
      default: begin
        op_a = key_q[15:8];
        op_b = key_q[7:0];
      end
    endcase
    prod   = op_a * op_b;
    prod_n = PW'(acc) * PW'(RECIP_N);
    prod_3 = PW'(acc) * PW'(RECIP_3);
    rem_n  = acc - SUM_W'(qn * SUM_W'(TABLE_SIZE));
    rem_3  = acc - SUM_W'(q3 * SUM_W'(3));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hstate <= H_IDLE;
      done   <= 1'b0;
    end else begin
      done <= (hstate == H_REM);
      case (hstate)
        H_IDLE: begin
          if (start) begin
            key_q  <= key;
            acc    <= '0;
            cnt    <= '0;
            hstate <= H_MUL;
          end
        end
        H_MUL: begin
          acc <= acc + SUM_W'(prod);
          if (cnt == 2'd2) begin
            hstate <= H_DIV;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        H_DIV: begin
          qn     <= SUM_W'(prod_n >> SHN);
          q3     <= SUM_W'(prod_3 >> SH3);
          hstate <= H_REM;
        end
        H_REM: begin
          rn     <= rem_n[IW-1:0];
          r3     <= rem_3[1:0];
          hstate <= H_IDLE;
        end
        default: hstate <= H_IDLE;
      endcase
    end
  end

  always_comb begin
    step_raw = (IW + 1)'(2'd3 - r3);
    step_red = (step_raw >= NV) ? step_raw - NV : step_raw;
    home     = rn;
    step     = step_red[IW-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/dht_mem.sv @@
// Slot store: one memory of mark and key per slot, registered read port,
// and a valid bit per slot so that unwritten slots read as empty.
// Depends on dht_pkg.
`default_nettype none

module dht_mem import dht_pkg::*; #(
  parameter int TABLE_SIZE = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mem_req_t         req,
  output logic [1:0]            rd_mark,
  output logic [KEY_W-1:0]      rd_key
);

  localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  logic [KEY_W+1:0]      mem [TABLE_SIZE];
  logic [KEY_W+1:0]      rd_row;
  logic [TABLE_SIZE-1:0] valid;
  logic                  rd_ok;
  logic [IW-1:0]         a;

  assign a = req.addr[IW-1:0];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[a] <= {req.wmark, req.wkey};
    end
    if (req.rd_en) begin
      rd_row <= mem[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (req.we) begin
        valid[a] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_ok <= valid[a];
      end
    end
  end

  assign rd_mark = rd_ok ? rd_row[KEY_W+1:KEY_W] : MARK_EMPTY;
  assign rd_key  = rd_row[KEY_W-1:0];

endmodule

`default_nettype wire

@@ rtl/double_hash_table.sv @@
// With the output free, a read passes from decode through a memory read and a check to the
// result; delete and out-of-range indexes go from decode straight to the result. Insert and
// search first wait for hashing (one multiplier over the byte pairs, then reciprocal and
// remainder steps), then read each probed slot in a read and a check state through the single memory port.
// One item is in work at a time; the next transfer can be taken the cycle after the result is
// issued, and a finished result waits in S_DONE until the output register is free.
// Synchronous reset empties every slot at once through per-slot valid bits; no clearing pass.
// Depends on dht_pkg, dht_hash and dht_mem.
`default_nettype none

module double_hash_table import dht_pkg::*; #(
  parameter int TABLE_SIZE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // key_value [47:0], slot_index [55:48]
  input  wire logic [1:0]  s_axis_tuser,  // operation [1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // slot_found [7:0], key_out [55:8]
  output logic [3:0]       m_axis_tuser   // status [3:0]
);

  localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CW = $clog2(TABLE_SIZE + 2);
  localparam logic [IW:0] NV = (IW + 1)'(TABLE_SIZE);
  localparam logic [CW-1:0] LAST_PROBE = CW'(TABLE_SIZE + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_HASH   = 6'b000100,
    S_RD     = 6'b001000,
    S_CHK    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t            state;
  op_t               op_q;
  logic [KEY_W-1:0]  key_q;
  logic [SLOT_W-1:0] idx_q;
  logic [IW-1:0]     home;
  logic [IW-1:0]     stepm;
  logic [IW-1:0]     p;
  logic [CW-1:0]     i;
  logic [KEY_W-1:0]  evict_key;
  logic [STAT_W-1:0] res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [KEY_W-1:0]  res_key;

  logic              hash_start;
  logic              hash_done;
  logic [IW-1:0]     hash_home;
  logic [IW-1:0]     hash_step;
  mem_req_t          mem_req;
  logic [1:0]        rd_mark;
  logic [KEY_W-1:0]  rd_key;

  logic              accept;
  logic              out_free;
  logic              bad_idx;
  logic              last;
  logic [IW:0]       q;
  logic [IW-1:0]     p_nx;
  logic              ins_home;
  logic              ins_probe;
  logic              ins_evict;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign hash_start    = (state == S_DECODE) && (op_q == OP_INSERT || op_q == OP_SEARCH);
  assign bad_idx       = {1'b0, idx_q} >= (SLOT_W + 1)'(TABLE_SIZE);
  assign last          = (i == LAST_PROBE);

  always_comb begin
    q    = {1'b0, p} + {1'b0, stepm};
    p_nx = (q >= NV) ? q[IW-1:0] - NV[IW-1:0] : q[IW-1:0];
  end

  assign ins_home  = (i == '0) && (rd_mark != MARK_OCCUPIED);
  assign ins_probe = (i != '0) && (rd_mark == MARK_EMPTY);
  assign ins_evict = (i != '0) && (rd_mark != MARK_EMPTY) && last;

  always_comb begin
    mem_req       = '0;
    mem_req.addr  = SLOT_W'(p);
    mem_req.wkey  = key_q;
    mem_req.wmark = MARK_OCCUPIED;
    case (state)
      S_RD: mem_req.rd_en = 1'b1;
      S_DECODE: begin
        if (op_q == OP_DELETE && !bad_idx) begin
          mem_req.we    = 1'b1;
          mem_req.addr  = idx_q;
          mem_req.wmark = MARK_DELETED;
        end
      end
      S_CHK: begin
        if (op_q == OP_INSERT && (ins_home || ins_probe || ins_evict)) begin
          mem_req.we = 1'b1;
          if (ins_evict) begin
            mem_req.addr = SLOT_W'(home);
          end
        end
      end
      default: mem_req.we = 1'b0;
    endcase
  end

  dht_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key_q),
    .done  (hash_done),
    .home  (hash_home),
    .step  (hash_step)
  );

  dht_mem #(.TABLE_SIZE(TABLE_SIZE)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_mark (rd_mark),
    .rd_key  (rd_key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= op_t'(s_axis_tuser);
            key_q <= s_axis_tdata[47:0];
            idx_q <= s_axis_tdata[55:48];
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_key  <= '0;
          res_slot <= (op_q == OP_DELETE && !bad_idx) ? idx_q : '0;
          case (op_q)
            OP_INSERT, OP_SEARCH: state <= S_HASH;
            OP_READ: begin
              if (bad_idx) begin
                res_status <= ST_BAD_INDEX;
                state      <= S_DONE;
              end else begin
                p     <= idx_q[IW-1:0];
                state <= S_RD;
              end
            end
            default: begin
              if (bad_idx) begin
                res_status <= ST_BAD_INDEX;
              end else begin
                res_status <= ST_REMOVED;
              end
              state <= S_DONE;
            end
          endcase
        end
        S_HASH: begin
          if (hash_done) begin
            home  <= hash_home;
            stepm <= hash_step;
            p     <= hash_home;
            i     <= '0;
            state <= S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          case (op_q)
            OP_INSERT: begin
              if (ins_home) begin
                res_status <= ST_HOME;
                res_slot   <= SLOT_W'(p);
                state      <= S_DONE;
              end else if (ins_probe) begin
                res_status <= ST_PROBED;
                res_slot   <= SLOT_W'(p);
                state      <= S_DONE;
              end else if (ins_evict) begin
                res_status <= ST_EVICTED;
                res_slot   <= SLOT_W'(home);
                res_key    <= evict_key;
                state      <= S_DONE;
              end else begin
                if (i == '0) begin
                  evict_key <= rd_key;
                end
                p     <= p_nx;
                i     <= i + CW'(1);
                state <= S_RD;
              end
            end
            OP_SEARCH: begin
              if (rd_mark == MARK_EMPTY) begin
                res_status <= ST_NOT_FOUND;
                state      <= S_DONE;
              end else if (rd_mark == MARK_OCCUPIED && rd_key == key_q) begin
                res_status <= ST_FOUND;
                res_slot   <= SLOT_W'(p);
                state      <= S_DONE;
              end else if (last) begin
                res_status <= ST_NOT_FOUND;
                state      <= S_DONE;
              end else begin
                p     <= p_nx;
                i     <= i + CW'(1);
                state <= S_RD;
              end
            end
            default: begin
              res_slot <= idx_q;
              if (rd_mark == MARK_OCCUPIED) begin
                res_status <= ST_OCCUPIED;
                res_key    <= rd_key;
              end else if (rd_mark == MARK_DELETED) begin
                res_status <= ST_DELETED;
              end else begin
                res_status <= ST_EMPTY;
              end
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {res_key, res_slot};
      m_axis_tuser  <= res_status;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.we && mem_req.rd_en))
    else $error("memory written and read in the same cycle");

  a_hash_done_in_hash: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> state == S_HASH)
    else $error("hash result arrived outside the hash wait");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && m_axis_tvalid && !m_axis_tready) |=> state == S_DONE)
    else $error("result left the sequencer while the output was stalled");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    i <= LAST_PROBE)
    else $error("probe count ran past the table bound");

  a_chk_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> $past(state) == S_RD)
    else $error("slot check without a preceding memory read");

endmodule

`default_nettype wire

@@ tb/tb_double_hash_table.sv @@
// Self-checking testbench for double_hash_table: insert, search, read and delete
// transfers with random bursts and output stalls, checked against a local table model.
// Depends on dht_pkg and the double_hash_table RTL.
`timescale 1ns / 100ps

module tb_double_hash_table;
  import dht_pkg::*;

  localparam int TABLE_SIZE   = 16;
  localparam int RANDOM_ITEMS = 1430;
  localparam int SETTLE_CYCLES = 2 * TABLE_SIZE + 60;
  localparam realtime TIMEOUT = 600000 * 12ns;

  typedef struct {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    bit                drain;
  } table_op_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // key_value [47:0], slot_index [55:48]
  logic [1:0]  s_axis_tuser = '0;  // operation [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;       // slot_found [7:0], key_out [55:8]
  logic [3:0]  m_axis_tuser;       // status [3:0]

  table_op_t    pending_ops[$];
  table_reply_t expected_replies[$];
  logic [KEY_W-1:0] inserted_keys[$];

  logic [KEY_W-1:0] model_keys[TABLE_SIZE];
  logic [1:0]       model_marks[TABLE_SIZE];

  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int status_count[16];
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_phase = 0;

  double_hash_table #(.TABLE_SIZE(TABLE_SIZE)) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic table_reply_t apply_table_op(op_t op, logic [KEY_W-1:0] key,
                                                  logic [SLOT_W-1:0] idx);
    int unsigned  sum;
    int unsigned  home;
    int unsigned  step;
    int unsigned  p;
    table_reply_t r;
    sum  = key[47:40] * key[39:32] + key[31:24] * key[23:16] + key[15:8] * key[7:0];
    home = sum % TABLE_SIZE;
    step = 3 - (sum % 3);
    r = '{status: ST_NOT_FOUND, slot: '0, key: '0};
    case (op)
      OP_INSERT: begin
        if (model_marks[home] != MARK_OCCUPIED) begin
          model_keys[home]  = key;
          model_marks[home] = MARK_OCCUPIED;
          r.status = ST_HOME;
          r.slot   = SLOT_W'(home);
          return r;
        end
        for (int i = 1; i <= TABLE_SIZE + 1; i++) begin
          p = (home + i * step) % TABLE_SIZE;
          if (model_marks[p] == MARK_EMPTY) begin
            model_keys[p]  = key;
            model_marks[p] = MARK_OCCUPIED;
            r.status = ST_PROBED;
            r.slot   = SLOT_W'(p);
            return r;
          end
        end
        r.status = ST_EVICTED;
        r.slot   = SLOT_W'(home);
        r.key    = model_keys[home];
        model_keys[home] = key;
      end
      OP_SEARCH: begin
        for (int i = 0; i <= TABLE_SIZE + 1; i++) begin
          p = (home + i * step) % TABLE_SIZE;
          if (model_marks[p] == MARK_EMPTY) break;
          if (model_marks[p] == MARK_OCCUPIED && model_keys[p] == key) begin
            r.status = ST_FOUND;
            r.slot   = SLOT_W'(p);
            return r;
          end
        end
      end
      default: begin
        if (idx >= TABLE_SIZE) begin
          r.status = ST_BAD_INDEX;
        end else if (op == OP_READ) begin
          r.slot = idx;
          if (model_marks[idx] == MARK_OCCUPIED) begin
            r.status = ST_OCCUPIED;
            r.key    = model_keys[idx];
          end else if (model_marks[idx] == MARK_DELETED) begin
            r.status = ST_DELETED;
          end else begin
            r.status = ST_EMPTY;
          end
        end else begin
          model_marks[idx] = MARK_DELETED;
          r.status = ST_REMOVED;
          r.slot   = idx;
        end
      end
    endcase
    return r;
  endfunction

  task automatic add_op(op_t op, logic [KEY_W-1:0] key, logic [SLOT_W-1:0] slot,
                        bit drain = 1'b0);
    pending_ops.push_back('{op: op, key: key, slot: slot, drain: drain});
    if (op == OP_INSERT) inserted_keys.push_back(key);
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: k = k & 48'h0F0F0F0F0F0F;
      1: k = k | 48'hF0F0F0F0F0F0;
      default: ;
    endcase
    return k;
  endfunction

  function automatic logic [SLOT_W-1:0] random_slot();
    if ($urandom_range(0, 7) == 0) return SLOT_W'($urandom_range(0, 255));
    return SLOT_W'($urandom_range(0, TABLE_SIZE - 1));
  endfunction

  function automatic logic [KEY_W-1:0] known_key();
    if (inserted_keys.size() == 0 || $urandom_range(0, 3) == 0) return random_key();
    return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
  endfunction

  task automatic build_stimulus();
    logic [KEY_W-1:0] k;
    int n;
    // Directed: empty reads, bad indexes, home and probed inserts, duplicates,
    // searches past deleted and mismatching slots, reuse of a deleted home.
    add_op(OP_READ,   random_key(), 8'd0);
    add_op(OP_READ,   random_key(), 8'd255);
    add_op(OP_DELETE, random_key(), 8'd16);
    add_op(OP_READ,   random_key(), 8'(TABLE_SIZE - 1));
    add_op(OP_INSERT, 48'h0, 8'd255);
    add_op(OP_INSERT, 48'h0, 8'd0);
    add_op(OP_SEARCH, 48'h0, 8'd0);
    add_op(OP_INSERT, 48'hFFFF_FFFF_FFFF, 8'd0);
    add_op(OP_SEARCH, 48'hFFFF_FFFF_FFFF, 8'd255);
    add_op(OP_SEARCH, 48'h0000_0000_0001, 8'd0);
    add_op(OP_DELETE, random_key(), 8'd0);
    add_op(OP_READ,   random_key(), 8'd0);
    add_op(OP_SEARCH, 48'h0, 8'd0);
    add_op(OP_INSERT, 48'h0, 8'd0);
    add_op(OP_DELETE, random_key(), 8'(TABLE_SIZE - 1));
    add_op(OP_READ,   random_key(), 8'(TABLE_SIZE - 1));
    add_op(OP_DELETE, random_key(), 8'(TABLE_SIZE - 1));
    add_op(OP_READ,   random_key(), 8'd3);
    add_op(OP_READ,   random_key(), 8'd6, 1'b1);
    add_op(OP_SEARCH, 48'h1234_5678_9ABC, 8'd0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        k = random_key();
        add_op(OP_INSERT, k, random_slot(), (n % 300) == 299);
        add_op(OP_SEARCH, k, random_slot());
        add_op(OP_READ, random_key(), random_slot());
        n += 3;
        if ($urandom_range(0, 2) == 0) begin
          add_op(OP_DELETE, random_key(), random_slot());
          add_op(OP_SEARCH, k, random_slot());
          n += 2;
        end
      end else begin
        case ($urandom_range(0, 3))
          0: add_op(OP_INSERT, random_key(), random_slot());
          1: add_op(OP_SEARCH, known_key(), random_slot());
          2: add_op(OP_READ,   random_key(), random_slot());
          default: add_op(OP_DELETE, random_key(), random_slot());
        endcase
        n++;
      end
    end
  endtask

  always @(posedge clk) begin : driver
    table_op_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (pending_ops[0].drain && (s_axis_tvalid || expected_replies.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nxt.slot, nxt.key};
        s_axis_tuser  <= nxt.op;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_phase <= (stall_phase + 1) % 5;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_phase != 0);
    endcase
  end

  always @(posedge clk) begin : monitor
    table_reply_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_replies.size() == 0) begin
          $error("result with no outstanding request: status %0d", m_axis_tuser);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          checked++;
          status_count[want.status]++;
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[7:0] !== want.slot) begin
            $error("slot_found: expected %0d, got %0d", want.slot, m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tdata[55:8] !== want.key) begin
            $error("key_out: expected %h, got %h", want.key, m_axis_tdata[55:8]);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(apply_table_op(op_t'(s_axis_tuser), s_axis_tdata[47:0],
                                                  s_axis_tdata[55:48]));
        accepted++;
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      model_keys[i]  = '0;
      model_marks[i] = MARK_EMPTY;
    end
    build_stimulus();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending_ops.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results for %0d requests: %0d home, %0d probed, %0d evicted,",
             checked, accepted, status_count[ST_HOME], status_count[ST_PROBED],
             status_count[ST_EVICTED]);
    $display("  %0d found, %0d not found, %0d reads, %0d removed, %0d bad index.",
             status_count[ST_FOUND], status_count[ST_NOT_FOUND],
             status_count[ST_OCCUPIED] + status_count[ST_EMPTY] + status_count[ST_DELETED],
             status_count[ST_REMOVED], status_count[ST_BAD_INDEX]);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("FAILURE");
    $finish;
  end

endmodule
